// File: sv/sbmr_pkg.sv
// Shared constants, register codes and control types of the block mask reduction.
package sbmr_pkg;

  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_BLOCKS_H = 8;
  localparam int MAX_BLOCKS_W = 8;
  localparam int OFFSET_H     = 0;
  localparam int OFFSET_W     = 0;

  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int HPOS_W = $clog2(MAX_HEIGHT + 1);
  localparam int WPOS_W = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;

  localparam int PIX_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_W    = 5;
  localparam int NBLK_W    = 4;
  localparam int IDX_W     = 3;
  localparam int STEP_W    = IDX_W + SIZE_W;
  localparam int AREA_W    = 2 * SIZE_W;
  localparam int SUM_W     = PIX_W + AREA_W;
  localparam int PROD_W    = PIX_W + AREA_W + 1;
  localparam int CRD_W     = HPOS_W + WPOS_W + STEP_W;
  localparam int FRAME_W   = 8;
  localparam int COUNT_W   = 15;
  localparam int COUNT_MAX = 16384;
  localparam int FRAME_MAX = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_AVG_POOL      = 3'd1,
    CFG_BLOCK_HEIGHT  = 3'd2,
    CFG_BLOCK_WIDTH   = 3'd3,
    CFG_STRIDE_HEIGHT = 3'd4,
    CFG_STRIDE_WIDTH  = 3'd5,
    CFG_BLOCKS_HIGH   = 3'd6,
    CFG_BLOCKS_WIDE   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic read;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic grid_empty;
    logic win_empty;
    logic rd_last;
    logic blk_last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/sbmr_mask_if.sv
// Request channel carrying one mask pixel and its row, frame and batch marks.
interface sbmr_mask_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbmr_pkg::PIX_W-1:0]   mask_value;
  logic                                row_end;
  logic                                frame_end;
  logic                                batch_end;

  modport source(output valid, mask_value, row_end, frame_end, batch_end, input ready);
  modport sink(input valid, mask_value, row_end, frame_end, batch_end, output ready);
endinterface

// File: sv/sbmr_result_if.sv
// Request channel carrying one active block result.
interface sbmr_result_if;
  logic                                valid;
  logic                                ready;
  logic [sbmr_pkg::FRAME_W-1:0]        batch_index;
  logic [sbmr_pkg::IDX_W-1:0]          block_row;
  logic [sbmr_pkg::IDX_W-1:0]          block_col;
  logic                                block_valid;
  logic                                last_of_run;
  logic [sbmr_pkg::COUNT_W-1:0]        active_count;

  modport source(output valid, batch_index, block_row, block_col, block_valid,
                 last_of_run, active_count, input ready);
  modport sink(input valid, batch_index, block_row, block_col, block_valid,
               last_of_run, active_count, output ready);
endinterface

// File: sv/sbmr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sbmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: sv/sbmr_ctrl.sv
// Controller state machine sequencing pixel load, block walk and result issue.
module sbmr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_frame_end,
  output logic          in_ready,
  input  sbmr_pkg::sts_t sts,
  output sbmr_pkg::cmd_t cmd
);
  import sbmr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_frame_end) begin
            state_next = sts.grid_empty ? ST_FINISH : ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.win_empty ? ST_DECIDE : ST_READ;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (sts.rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.out_free) begin
          cmd.decide = 1'b1;
          state_next = sts.blk_last ? ST_FINISH : ST_SETUP;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// File: sv/sbmr_datapath.sv
// Datapath: configuration, pixel store addressing, window walk, accumulation and results.
module sbmr_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sbmr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbmr_pkg::CFG_W-1:0]           cfg_data,
  input  logic signed [sbmr_pkg::PIX_W-1:0]    pix_value,
  input  logic                                 pix_row_end,
  input  logic                                 pix_frame_end,
  input  logic                                 pix_batch_end,
  input  sbmr_pkg::cmd_t                       cmd,
  output sbmr_pkg::sts_t                       sts,
  output logic                                 wr_en,
  output logic [sbmr_pkg::ADDR_W-1:0]          wr_addr,
  output logic [sbmr_pkg::PIX_W-1:0]           wr_data,
  output logic                                 rd_en,
  output logic [sbmr_pkg::ADDR_W-1:0]          rd_addr,
  input  logic [sbmr_pkg::PIX_W-1:0]           rd_data,
  sbmr_result_if.source                        res
);
  import sbmr_pkg::*;

  logic signed [PIX_W-1:0]  threshold;
  logic                     avg_pool;
  logic [SIZE_W-1:0]        block_height;
  logic [SIZE_W-1:0]        block_width;
  logic [SIZE_W-1:0]        stride_height;
  logic [SIZE_W-1:0]        stride_width;
  logic [NBLK_W-1:0]        blocks_high;
  logic [NBLK_W-1:0]        blocks_wide;

  logic [WPOS_W-1:0]        col_pos;
  logic [HPOS_W-1:0]        row_pos;
  logic [WPOS_W-1:0]        frame_width;
  logic [HPOS_W-1:0]        frame_height;
  logic [FRAME_W-1:0]       frame_number;
  logic [COUNT_W-1:0]       running_count;
  logic                     batch_flag;
  logic signed [PROD_W-1:0] limit;

  logic [IDX_W-1:0]         bh_idx;
  logic [IDX_W-1:0]         bw_idx;
  logic [HPOS_W-1:0]        h_cur;
  logic [HPOS_W-1:0]        h_end;
  logic [WPOS_W-1:0]        w_cur;
  logic [WPOS_W-1:0]        w_start;
  logic [WPOS_W-1:0]        w_end;
  logic                     rd_vld;
  logic signed [SUM_W-1:0]  sum;
  logic                     any;

  logic                     pend_valid;
  logic [IDX_W-1:0]         pend_row;
  logic [IDX_W-1:0]         pend_col;
  logic [COUNT_W-1:0]       pend_count;

  logic [NBLK_W-1:0]        nbh;
  logic [NBLK_W-1:0]        nbw;
  logic [STEP_W-1:0]        h_step;
  logic [STEP_W-1:0]        w_step;
  logic signed [CRD_W-1:0]  h0, w0, hs, ws, he, we, he_raw, we_raw, fh_s, fw_s;
  logic [WPOS_W-1:0]        width_next;
  logic [HPOS_W-1:0]        height_next;
  logic                     active;
  logic [COUNT_W-1:0]       count_next;
  logic [AREA_W-1:0]        area;
  logic                     push;
  logic [FRAME_W-1:0]       o_index;
  logic [IDX_W-1:0]         o_row;
  logic [IDX_W-1:0]         o_col;
  logic                     o_bvalid;
  logic                     o_last;
  logic [COUNT_W-1:0]       o_count;

  assign nbh = (blocks_high > NBLK_W'(MAX_BLOCKS_H)) ? NBLK_W'(MAX_BLOCKS_H) : blocks_high;
  assign nbw = (blocks_wide > NBLK_W'(MAX_BLOCKS_W)) ? NBLK_W'(MAX_BLOCKS_W) : blocks_wide;
  assign area = AREA_W'(block_height * block_width);

  assign width_next  = (col_pos < WPOS_W'(MAX_WIDTH)) ? col_pos + 1'b1 : WPOS_W'(MAX_WIDTH);
  assign height_next = (row_pos < HPOS_W'(MAX_HEIGHT)) ? row_pos + 1'b1 : HPOS_W'(MAX_HEIGHT);

  assign wr_en   = cmd.load && (row_pos < HPOS_W'(MAX_HEIGHT)) && (col_pos < WPOS_W'(MAX_WIDTH));
  assign wr_addr = {row_pos[ROW_W-1:0], col_pos[COL_W-1:0]};
  assign wr_data = pix_value;
  assign rd_en   = cmd.read;
  assign rd_addr = {h_cur[ROW_W-1:0], w_cur[COL_W-1:0]};

  always_comb begin
    h_step = STEP_W'(bh_idx * stride_height);
    w_step = STEP_W'(bw_idx * stride_width);
    h0     = CRD_W'(OFFSET_H) + $signed(CRD_W'(h_step));
    w0     = CRD_W'(OFFSET_W) + $signed(CRD_W'(w_step));
    hs     = (h0 < 0) ? '0 : h0;
    ws     = (w0 < 0) ? '0 : w0;
    he_raw = h0 + $signed(CRD_W'(block_height));
    we_raw = w0 + $signed(CRD_W'(block_width));
    fh_s   = $signed(CRD_W'(frame_height));
    fw_s   = $signed(CRD_W'(frame_width));
    he     = (he_raw > fh_s) ? fh_s : he_raw;
    we     = (we_raw > fw_s) ? fw_s : we_raw;
  end

  assign active = avg_pool
      ? ($signed({{(PROD_W-SUM_W){sum[SUM_W-1]}}, sum}) > limit)
      : any;
  assign count_next = (running_count < COUNT_W'(COUNT_MAX)) ? running_count + 1'b1
                                                            : running_count;

  assign sts.grid_empty = (nbh == '0) || (nbw == '0);
  assign sts.win_empty  = (he <= hs) || (we <= ws);
  assign sts.rd_last    = (h_cur == h_end - 1'b1) && (w_cur == w_end - 1'b1);
  assign sts.blk_last   = ({1'b0, bh_idx} == nbh - 1'b1) && ({1'b0, bw_idx} == nbw - 1'b1);
  assign sts.out_free   = !res.valid || res.ready;

  always_comb begin
    push     = 1'b0;
    o_index  = frame_number;
    o_row    = pend_row;
    o_col    = pend_col;
    o_bvalid = 1'b1;
    o_last   = 1'b0;
    o_count  = pend_count;
    if (cmd.decide && active && pend_valid) begin
      push = 1'b1;
    end else if (cmd.finish) begin
      push   = 1'b1;
      o_last = 1'b1;
      if (!pend_valid) begin
        o_row    = '0;
        o_col    = '0;
        o_bvalid = 1'b0;
        o_count  = running_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= '0;
      avg_pool      <= 1'b0;
      block_height  <= SIZE_W'(8);
      block_width   <= SIZE_W'(8);
      stride_height <= SIZE_W'(8);
      stride_width  <= SIZE_W'(8);
      blocks_high   <= NBLK_W'(8);
      blocks_wide   <= NBLK_W'(8);
      col_pos       <= '0;
      row_pos       <= '0;
      frame_width   <= '0;
      frame_height  <= '0;
      frame_number  <= '0;
      running_count <= '0;
      batch_flag    <= 1'b0;
      bh_idx        <= '0;
      bw_idx        <= '0;
      rd_vld        <= 1'b0;
      pend_valid    <= 1'b0;
      res.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD:     threshold     <= $signed(cfg_data[PIX_W-1:0]);
          CFG_AVG_POOL:      avg_pool      <= cfg_data[0];
          CFG_BLOCK_HEIGHT:  block_height  <= cfg_data[SIZE_W-1:0];
          CFG_BLOCK_WIDTH:   block_width   <= cfg_data[SIZE_W-1:0];
          CFG_STRIDE_HEIGHT: stride_height <= cfg_data[SIZE_W-1:0];
          CFG_STRIDE_WIDTH:  stride_width  <= cfg_data[SIZE_W-1:0];
          CFG_BLOCKS_HIGH:   blocks_high   <= cfg_data[NBLK_W-1:0];
          CFG_BLOCKS_WIDE:   blocks_wide   <= cfg_data[NBLK_W-1:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        if (!(pix_row_end || pix_frame_end)) begin
          if (col_pos < WPOS_W'(MAX_WIDTH)) begin
            col_pos <= col_pos + 1'b1;
          end
        end else begin
          frame_width <= width_next;
          col_pos     <= '0;
          if (!pix_frame_end) begin
            row_pos <= height_next;
          end else begin
            frame_height <= height_next;
            row_pos      <= '0;
            batch_flag   <= pix_batch_end;
            limit        <= PROD_W'(threshold * $signed({1'b0, area}));
            bh_idx       <= '0;
            bw_idx       <= '0;
          end
        end
      end

      if (cmd.setup) begin
        h_cur   <= hs[HPOS_W-1:0];
        h_end   <= he[HPOS_W-1:0];
        w_cur   <= ws[WPOS_W-1:0];
        w_start <= ws[WPOS_W-1:0];
        w_end   <= we[WPOS_W-1:0];
        sum     <= '0;
        any     <= 1'b0;
      end

      if (cmd.read) begin
        if (w_cur == w_end - 1'b1) begin
          w_cur <= w_start;
          h_cur <= h_cur + 1'b1;
        end else begin
          w_cur <= w_cur + 1'b1;
        end
      end

      rd_vld <= cmd.read;
      if (rd_vld) begin
        sum <= sum + {{(SUM_W-PIX_W){rd_data[PIX_W-1]}}, rd_data};
        if ($signed(rd_data) > threshold) begin
          any <= 1'b1;
        end
      end

      if (cmd.decide) begin
        if (active) begin
          running_count <= count_next;
          pend_valid    <= 1'b1;
          pend_row      <= bh_idx;
          pend_col      <= bw_idx;
          pend_count    <= count_next;
        end
        if ({1'b0, bw_idx} == nbw - 1'b1) begin
          bw_idx <= '0;
          bh_idx <= bh_idx + 1'b1;
        end else begin
          bw_idx <= bw_idx + 1'b1;
        end
      end

      if (cmd.finish) begin
        pend_valid <= 1'b0;
        if (batch_flag) begin
          frame_number  <= '0;
          running_count <= '0;
        end else if (frame_number < FRAME_W'(FRAME_MAX)) begin
          frame_number <= frame_number + 1'b1;
        end
      end

      if (push) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res.batch_index  <= o_index;
      res.block_row    <= o_row;
      res.block_col    <= o_col;
      res.block_valid  <= o_bvalid;
      res.last_of_run  <= o_last;
      res.active_count <= o_count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    running_count <= COUNT_W'(COUNT_MAX))
    else $error("running count above saturation");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (col_pos <= WPOS_W'(MAX_WIDTH)) && (row_pos <= HPOS_W'(MAX_HEIGHT)))
    else $error("load position out of range");

  a_read_window: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> (h_cur < h_end) && (w_cur < w_end))
    else $error("read outside block window");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> sts.out_free)
    else $error("result register overwritten");
endmodule

// File: sv/sparse_block_mask_reduce_top.sv
// Top level of the block mask reduction: controller, datapath and pixel store.
// Usage:
//  mask_in carries one Q8.8 pixel per request in raster order with row_end,
//  frame_end and batch_end marks; result_out carries one request per active
//  block (frame index, block row and column, running count) and flags the
//  final one of the frame with last_of_run, or a single empty result.
//  The user must write registers through cfg_we / cfg_index / cfg_data only while idle; the block does not enforce it.
// Timing:
//  A pixel that does not end a frame is written to the pixel store and keeps
//  mask_in ready for the next one. The frame-end pixel starts a walk over the
//  block grid that reads the pixel store one pixel per cycle: each block
//  passes through setup, its reads, a read drain and a decide step, an empty
//  window through setup and decide only, and a finish step closes the frame.
//  The single read port of the store sets this read rate. The first result
//  is registered when a second active block is decided, or when the walk ends.
//  mask_in.ready is low for the whole walk. A stalled result_out holds the
//  walk at its next decision until the result register frees.
//  Reset (rst, synchronous) clears positions, counters and registers to
//  their defaults; the pixel store is not cleared.
module sparse_block_mask_reduce_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbmr_pkg::CFG_W-1:0]      cfg_data,
  sbmr_mask_if.sink                       mask_in,
  sbmr_result_if.source                   result_out
);
  import sbmr_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;

  sbmr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (mask_in.valid),
    .in_frame_end (mask_in.frame_end),
    .in_ready     (mask_in.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  sbmr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pix_value     (mask_in.mask_value),
    .pix_row_end   (mask_in.row_end),
    .pix_frame_end (mask_in.frame_end),
    .pix_batch_end (mask_in.batch_end),
    .cmd           (cmd),
    .sts           (sts),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .res           (result_out)
  );

  sbmr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );
endmodule

// File: test/tb_mask_src.sv
// Pixel request and block result records of the testbench.
`timescale 1ns / 1ps
package tb_mask_types;
  typedef struct {
    logic signed [15:0] mask_value;
    logic               row_end;
    logic               frame_end;
    logic               batch_end;
  } pixel_req_t;

  typedef struct {
    logic [7:0]  batch_index;
    logic [2:0]  block_row;
    logic [2:0]  block_col;
    logic        block_valid;
    logic        last_of_run;
    logic [14:0] active_count;
  } block_res_t;
endpackage

// File: test/tb.sv
// Self-checking testbench of the block mask reduction with a built-in block predictor.
`timescale 1ns / 1ps
module tb;
  import sbmr_pkg::*;
  import tb_mask_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  sbmr_mask_if mask_ch();
  sbmr_result_if res_ch();

  sparse_block_mask_reduce_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mask_in(mask_ch), .result_out(res_ch)
  );

  logic signed [15:0] pix_store [0:MAX_HEIGHT*MAX_WIDTH-1];
  int unsigned cur_col, cur_row, cur_width, frame_num, blk_count;
  logic signed [15:0] thr;
  bit avg_mode;
  int unsigned blk_h, blk_w, str_h, str_w, n_high, n_wide;

  pixel_req_t pending_px[$];
  block_res_t expected_blocks[$];
  int errors = 0;
  int gap_left = 0, burst_left = 0;
  int cur_w, cur_h;

  initial forever #5 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic bit block_is_active(int h0, int w0, int fh, int fw);
    int he, we;
    longint sum;
    bit any;
    sum = 0;
    any = 0;
    he = h0 + blk_h;
    we = w0 + blk_w;
    if (he > fh) he = fh;
    if (we > fw) we = fw;
    for (int h = h0; h < he; h++)
      for (int w = w0; w < we; w++) begin
        sum += pix_store[h*MAX_WIDTH+w];
        if (pix_store[h*MAX_WIDTH+w] > thr) any = 1;
      end
    if (avg_mode) return sum > longint'(thr) * longint'(blk_h * blk_w);
    return any;
  endfunction

  task automatic predict_pixel(input pixel_req_t p);
    int fh, n;
    block_res_t r;
    n = 0;
    if (cur_row < MAX_HEIGHT && cur_col < MAX_WIDTH)
      pix_store[cur_row*MAX_WIDTH+cur_col] = p.mask_value;
    if (!(p.row_end || p.frame_end)) begin
      if (cur_col < MAX_WIDTH) cur_col++;
      return;
    end
    cur_width = cur_col < MAX_WIDTH ? cur_col + 1 : MAX_WIDTH;
    cur_col = 0;
    if (!p.frame_end) begin
      if (cur_row < MAX_HEIGHT) cur_row++;
      return;
    end
    fh = cur_row < MAX_HEIGHT ? cur_row + 1 : MAX_HEIGHT;
    cur_row = 0;
    for (int bh = 0; bh < (n_high > 8 ? 8 : n_high); bh++)
      for (int bw = 0; bw < (n_wide > 8 ? 8 : n_wide); bw++)
        if (block_is_active(bh*str_h, bw*str_w, fh, cur_width)) begin
          if (blk_count < COUNT_MAX) blk_count++;
          r = '{frame_num[7:0], bh[2:0], bw[2:0], 1'b1, 1'b0, blk_count[14:0]};
          expected_blocks.push_back(r);
          n++;
        end
    if (n == 0) begin
      r = '{frame_num[7:0], 3'd0, 3'd0, 1'b0, 1'b1, blk_count[14:0]};
      expected_blocks.push_back(r);
    end else expected_blocks[$].last_of_run = 1'b1;
    if (p.batch_end) begin
      frame_num = 0;
      blk_count = 0;
    end else if (frame_num < 255) frame_num++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:     thr = val[15:0];
      CFG_AVG_POOL:      avg_mode = val[0];
      CFG_BLOCK_HEIGHT:  blk_h = val[4:0];
      CFG_BLOCK_WIDTH:   blk_w = val[4:0];
      CFG_STRIDE_HEIGHT: str_h = val[4:0];
      CFG_STRIDE_WIDTH:  str_w = val[4:0];
      CFG_BLOCKS_HIGH:   n_high = val[3:0];
      default:           n_wide = val[3:0];
    endcase
  endtask

  function automatic logic signed [15:0] rand_pix(int mode);
    case (mode)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_frame(input int h, input int w, input bit bend, input int mode);
    pixel_req_t p;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        p.mask_value = rand_pix(mode);
        p.row_end = (c == w - 1);
        p.frame_end = (c == w - 1) && (r == h - 1);
        p.batch_end = p.frame_end ? bend : ($urandom_range(0, 7) == 0);
        pending_px.push_back(p);
      end
  endtask

  task automatic drain();
    while (pending_px.size() != 0 || expected_blocks.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mask_ch.valid <= 1'b0;
    end else if (!mask_ch.valid || mask_ch.ready) begin
      if (mask_ch.valid) begin
        predict_pixel('{mask_ch.mask_value, mask_ch.row_end, mask_ch.frame_end,
                        mask_ch.batch_end});
        void'(pending_px.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        mask_ch.valid <= 1'b0;
      end else if (pending_px.size() != 0) begin
        pixel_req_t nx;
        nx = pending_px[0];
        mask_ch.valid <= 1'b1;
        mask_ch.mask_value <= nx.mask_value;
        mask_ch.row_end <= nx.row_end;
        mask_ch.frame_end <= nx.frame_end;
        mask_ch.batch_end <= nx.batch_end;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
        end
      end else mask_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_blocks.size() == 0) report("result with nothing expected");
        else begin
          block_res_t e;
          e = expected_blocks.pop_front();
          if (res_ch.batch_index !== e.batch_index) report("batch_index");
          if (res_ch.block_row !== e.block_row) report("block_row");
          if (res_ch.block_col !== e.block_col) report("block_col");
          if (res_ch.block_valid !== e.block_valid) report("block_valid");
          if (res_ch.last_of_run !== e.last_of_run) report("last_of_run");
          if (res_ch.active_count !== e.active_count) report("active_count");
        end
      end
      res_ch.ready <= ($time / 800) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    mask_ch.valid = 1'b0;
    mask_ch.mask_value = '0;
    mask_ch.row_end = 1'b0;
    mask_ch.frame_end = 1'b0;
    mask_ch.batch_end = 1'b0;
    res_ch.ready = 1'b0;
    cur_col = 0; cur_row = 0; cur_width = 0; frame_num = 0; blk_count = 0;
    thr = 0; avg_mode = 0; blk_h = 8; blk_w = 8; str_h = 8; str_w = 8;
    n_high = 8; n_wide = 8;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    queue_frame(2, 3, 1'b0, 0);
    queue_frame(1, 1, 1'b0, 1);
    queue_frame(3, 2, 1'b1, 2);
    drain();
    write_reg(CFG_THRESHOLD, 16'sh8000);
    write_reg(CFG_AVG_POOL, 1);
    write_reg(CFG_BLOCK_HEIGHT, 1);
    write_reg(CFG_BLOCK_WIDTH, 16);
    write_reg(CFG_STRIDE_HEIGHT, 1);
    write_reg(CFG_STRIDE_WIDTH, 16);
    write_reg(CFG_BLOCKS_HIGH, 1);
    write_reg(CFG_BLOCKS_WIDE, 8);
    queue_frame(4, 5, 1'b0, 2);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_THRESHOLD, ph == 0 ? 16'h7FFF : $urandom_range(0, 65535));
      write_reg(CFG_AVG_POOL, ph % 2);
      write_reg(CFG_BLOCK_HEIGHT, $urandom_range(1, 16));
      write_reg(CFG_BLOCK_WIDTH, $urandom_range(1, 16));
      write_reg(CFG_STRIDE_HEIGHT, $urandom_range(1, 16));
      write_reg(CFG_STRIDE_WIDTH, $urandom_range(1, 16));
      write_reg(CFG_BLOCKS_HIGH, $urandom_range(1, 8));
      write_reg(CFG_BLOCKS_WIDE, $urandom_range(1, 8));
      for (int f = 0; f < 4; f++) begin
        cur_h = $urandom_range(1, 4);
        cur_w = $urandom_range(1, 4);
        if (f == 0 && ph == 5) begin cur_h = 4; cur_w = 20; end
        queue_frame(cur_h, cur_w, $urandom_range(0, 3) == 0, 2);
      end
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: files.f
sv/sbmr_pkg.sv
sv/sbmr_mask_if.sv
sv/sbmr_result_if.sv
sv/sbmr_ram.sv
sv/sbmr_ctrl.sv
sv/sbmr_datapath.sv
sv/sparse_block_mask_reduce_top.sv
test/tb_mask_src.sv
test/tb.sv
